>>> rtl/md5_pkg.sv
// Package: shared types, round tables and helper functions for the MD5 digest block.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

    // Input item codes
    localparam logic ACTION_BYTE   = 1'b0;
    localparam logic ACTION_FINISH = 1'b1;

    // Block geometry
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_OFFSET  = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Initial chaining words
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // Block queue between front and core
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word_a;
        logic [31:0] digest_word_b;
        logic [31:0] digest_word_c;
        logic [31:0] digest_word_d;
    } digest_t;

    // Byte 0 of the block sits in the low bits
    typedef logic [63:0][7:0] block_t;

    typedef struct packed {
        logic   last;
        block_t block;
    } job_t;

    // Push side and status of the block queue
    typedef struct packed {
        logic push;
        job_t job;
    } queue_wr_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

    typedef enum logic {
        FRONT_FILL,
        FRONT_LEN_BLOCK
    } front_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_ADD,
        CORE_EMIT
    } core_state_t;

    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] round);
        logic [3:0] low;
        logic [3:0] idx;
        low = round[3:0];
        case (round[5:4])
            2'd0:    idx = low;
            2'd1:    idx = (low << 2) + low + 4'd1;
            2'd2:    idx = (low << 1) + low + 4'd5;
            default: idx = (low << 3) - low;
        endcase
        return idx;
    endfunction

    // Rotate amount of a round
    function automatic logic [4:0] rot_amount(input logic [5:0] round);
        return ROT_AMOUNT[{round[5:4], round[1:0]}];
    endfunction

    // Little-endian word of a block
    function automatic logic [31:0] block_word(input block_t blk, input logic [3:0] idx);
        return blk[{idx, 2'b00} +: 4];
    endfunction

endpackage

`default_nettype wire

>>> rtl/md5_front.sv
// Front end: packs message bytes into blocks, builds padding, pushes blocks to the queue.
`timescale 1ns / 1ps
`default_nettype none

module md5_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire md5_pkg::item_t        item,
    input  wire md5_pkg::queue_status_t q_status,
    output md5_pkg::queue_wr_t         q_wr
);

    md5_pkg::front_state_t state_reg, state_next;
    md5_pkg::block_t       block_reg;
    logic [5:0]            fill_reg, fill_next;
    logic [60:0]           count_reg, count_next;
    logic [63:0]           bits_reg;

    logic                  accept;
    logic [63:0]           bits_now;
    logic                  fits_len;
    md5_pkg::block_t       blk_with_byte;
    md5_pkg::block_t       blk_padded;
    md5_pkg::block_t       blk_len;

    // Build the padded tail block: keep bytes below the fill point, mark, zero, and the length when with_len is set
    function automatic md5_pkg::block_t pad_block(input md5_pkg::block_t blk,
                                                  input logic [5:0] pos,
                                                  input logic with_len,
                                                  input logic [63:0] bits);
        md5_pkg::block_t res;
        for (int j = 0; j < md5_pkg::BLOCK_BYTES; j++) begin
            if (6'(j) < pos) begin
                res[j] = blk[j];
            end else if (6'(j) == pos) begin
                res[j] = md5_pkg::PAD_BYTE;
            end else begin
                res[j] = 8'h00;
            end
        end
        if (with_len) begin
            res[63:56] = bits;
        end
        return res;
    endfunction

    // Hold input while the queue is full or the length block is pending
    assign item_stall = (state_reg == md5_pkg::FRONT_LEN_BLOCK) || q_status.full;
    assign accept     = item_valid && !item_stall;

    assign bits_now = {count_reg, 3'b000};
    assign fits_len = (fill_reg < 6'(md5_pkg::LEN_OFFSET));

    // Candidate blocks for the queue
    always_comb
    begin
        blk_with_byte           = block_reg;
        blk_with_byte[fill_reg] = item.data_byte;
        blk_padded              = pad_block(block_reg, fill_reg, fits_len, bits_now);
        blk_len                 = '0;
        blk_len[63:56]          = bits_reg;
    end

    // Next state and queue push
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        q_wr.push      = 1'b0;
        q_wr.job.last  = 1'b0;
        q_wr.job.block = blk_with_byte;
        unique case (state_reg)
            md5_pkg::FRONT_FILL:
            begin
                if (accept) begin
                    if (item.action == md5_pkg::ACTION_BYTE) begin
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        q_wr.push  = (fill_reg == 6'(md5_pkg::BLOCK_BYTES - 1));
                    end else begin
                        fill_next      = '0;
                        count_next     = '0;
                        q_wr.push      = 1'b1;
                        q_wr.job.last  = fits_len;
                        q_wr.job.block = blk_padded;
                        if (!fits_len) begin
                            state_next = md5_pkg::FRONT_LEN_BLOCK;
                        end
                    end
                end
            end
            md5_pkg::FRONT_LEN_BLOCK:
            begin
                q_wr.job.last  = 1'b1;
                q_wr.job.block = blk_len;
                if (!q_status.full) begin
                    q_wr.push  = 1'b1;
                    state_next = md5_pkg::FRONT_FILL;
                end
            end
            default:
            begin
                state_next = md5_pkg::FRONT_FILL;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= md5_pkg::FRONT_FILL;
            fill_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
        end
    end

    // Store bytes and latch the length for a second padding block
    always_ff @(posedge clk)
    begin
        if (accept && item.action == md5_pkg::ACTION_BYTE) begin
            block_reg[fill_reg] <= item.data_byte;
        end
        if (accept && item.action == md5_pkg::ACTION_FINISH) begin
            bits_reg <= bits_now;
        end
    end

endmodule

`default_nettype wire

>>> rtl/md5_job_queue.sv
// Two-entry queue of blocks waiting for compression.
`timescale 1ns / 1ps
`default_nettype none

module md5_job_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire md5_pkg::queue_wr_t     q_wr,
    input  wire logic                   pop,
    output md5_pkg::queue_status_t      q_status,
    output md5_pkg::job_t               head
);

    md5_pkg::job_t                entry_reg [md5_pkg::QUEUE_DEPTH];
    logic [md5_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [md5_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [md5_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign q_status.full  = (count_reg == md5_pkg::QCNT_W'(md5_pkg::QUEUE_DEPTH));
    assign q_status.valid = (count_reg != '0);
    assign head           = entry_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !q_status.full;
    assign do_pop  = pop && q_status.valid;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Write the pushed block
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= q_wr.job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/md5_core.sv
// Compression core: one MD5 round per cycle, chaining update and digest output register.
`timescale 1ns / 1ps
`default_nettype none

module md5_core (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire md5_pkg::queue_status_t  q_status,
    input  wire md5_pkg::job_t           head,
    output logic                         pop,
    output logic                         digest_valid,
    input  wire logic                    digest_stall,
    output md5_pkg::digest_t             digest
);

    md5_pkg::core_state_t state_reg, state_next;
    logic [5:0]           round_reg;
    logic [31:0]          a_reg, b_reg, c_reg, d_reg;
    logic [31:0]          km_reg;
    logic [31:0]          chain_a_reg, chain_b_reg, chain_c_reg, chain_d_reg;
    logic                 out_valid_reg;
    md5_pkg::digest_t     out_reg;

    logic [31:0]          f_val;
    logic [31:0]          sum;
    logic [63:0]          dbl;
    logic [31:0]          new_b;
    logic [5:0]           km_round;
    logic [31:0]          km_calc;
    logic                 out_free;

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;
    assign out_free     = !out_valid_reg || !digest_stall;

    // Round function and step
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum   = a_reg + f_val + km_reg;
        dbl   = {sum, sum} << md5_pkg::rot_amount(round_reg);
        new_b = b_reg + dbl[63:32];
    end

    // Constant plus message word, one round ahead
    assign km_round = (state_reg == md5_pkg::CORE_IDLE) ? 6'd0 : round_reg + 6'd1;
    assign km_calc  = md5_pkg::ROUND_ADD[km_round]
                    + md5_pkg::block_word(head.block, md5_pkg::msg_index(km_round));

    // Sequence load, rounds, chaining add and emit
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            md5_pkg::CORE_IDLE:
            begin
                if (q_status.valid) begin
                    state_next = md5_pkg::CORE_RUN;
                end
            end
            md5_pkg::CORE_RUN:
            begin
                if (round_reg == 6'd63) begin
                    state_next = md5_pkg::CORE_ADD;
                end
            end
            md5_pkg::CORE_ADD:
            begin
                pop        = 1'b1;
                state_next = head.last ? md5_pkg::CORE_EMIT : md5_pkg::CORE_IDLE;
            end
            md5_pkg::CORE_EMIT:
            begin
                if (out_free) begin
                    state_next = md5_pkg::CORE_IDLE;
                end
            end
            default:
            begin
                state_next = md5_pkg::CORE_IDLE;
            end
        endcase
    end

    // State, chaining words and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= md5_pkg::CORE_IDLE;
            round_reg     <= '0;
            chain_a_reg   <= md5_pkg::INIT_A;
            chain_b_reg   <= md5_pkg::INIT_B;
            chain_c_reg   <= md5_pkg::INIT_C;
            chain_d_reg   <= md5_pkg::INIT_D;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == md5_pkg::CORE_IDLE) begin
                round_reg <= '0;
            end else if (state_reg == md5_pkg::CORE_RUN) begin
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == md5_pkg::CORE_ADD) begin
                chain_a_reg <= chain_a_reg + a_reg;
                chain_b_reg <= chain_b_reg + b_reg;
                chain_c_reg <= chain_c_reg + c_reg;
                chain_d_reg <= chain_d_reg + d_reg;
            end else if (state_reg == md5_pkg::CORE_EMIT && out_free) begin
                chain_a_reg <= md5_pkg::INIT_A;
                chain_b_reg <= md5_pkg::INIT_B;
                chain_c_reg <= md5_pkg::INIT_C;
                chain_d_reg <= md5_pkg::INIT_D;
            end
            if (state_reg == md5_pkg::CORE_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && !digest_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working words, look-ahead sum and digest payload
    always_ff @(posedge clk)
    begin
        if (state_reg == md5_pkg::CORE_IDLE) begin
            a_reg  <= chain_a_reg;
            b_reg  <= chain_b_reg;
            c_reg  <= chain_c_reg;
            d_reg  <= chain_d_reg;
            km_reg <= km_calc;
        end else if (state_reg == md5_pkg::CORE_RUN) begin
            a_reg  <= d_reg;
            b_reg  <= new_b;
            c_reg  <= b_reg;
            d_reg  <= c_reg;
            km_reg <= km_calc;
        end
        if (state_reg == md5_pkg::CORE_EMIT && out_free) begin
            out_reg.digest_word_a <= chain_a_reg;
            out_reg.digest_word_b <= chain_b_reg;
            out_reg.digest_word_c <= chain_c_reg;
            out_reg.digest_word_d <= chain_d_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/md5_message_digest.sv
// Top level of the MD5 digest block: front end, block queue and compression core.
//
// Input channel (item_valid / item_stall / item): one transfer per message byte
// (action = byte) or one finish transfer that pads the message and asks for its digest.
// Bytes are taken one per cycle while the two-block queue has room; the front stalls
// when the queue is full and while it pushes the second padding block of a message
// whose tail leaves no room for the length.
// Each block passes through the core as one load, 64 rounds (one per cycle,
// set by the single round datapath) and one chaining add. The core works on one
// block at a time and takes the next queued block only after the chaining add.
// Output channel (digest_valid / digest_stall / digest): one transfer per finish,
// carrying the four chaining words. After the chaining add of a message's last
// block the core enters its emit state and registers the digest once the output
// register is free. The digest sits in an output register; while the receiver stalls
// it holds, and the core keeps compressing the next message's blocks, waiting only
// if a second digest is ready before the first is taken.
// Reset empties the queue, clears the byte count and loads the initial chaining words.
`timescale 1ns / 1ps
`default_nettype none

module md5_message_digest (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire md5_pkg::item_t    item,
    output logic                   digest_valid,
    input  wire logic              digest_stall,
    output md5_pkg::digest_t       digest
);

    md5_pkg::queue_wr_t     q_wr;
    md5_pkg::queue_status_t q_status;
    md5_pkg::job_t          head;
    logic                   pop;

    md5_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .q_wr       (q_wr)
    );

    md5_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_wr     (q_wr),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    md5_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

endmodule

`default_nettype wire
